// File: rtl/vlmh_pkg.sv
// Shared types and constants for the vision link mode handshake block.
`default_nettype none

package vlmh_pkg;

    localparam int MSG_W         = 48;
    localparam int MSG_MAX_BYTES = 8;
    localparam int Q_DEPTH       = 2;
    localparam int Q_AW          = 1;
    localparam int Q_CW          = 2;

    localparam logic [7:0] SYM_STX   = 8'h02;
    localparam logic [7:0] SYM_ETX   = 8'h03;
    localparam logic [7:0] SYM_PAD   = 8'hFF;
    localparam logic [7:0] TYPE_MODE = 8'h10;
    localparam logic [7:0] TYPE_CMD  = 8'h20;
    localparam logic [7:0] TYPE_ACK  = 8'h40;

    localparam logic [7:0] ACK_TEXT [3] = '{8'h41, 8'h43, 8'h4B};

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_KEY  = 2'd1,
        CMD_POLL = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_CMD_OK   = 3'd1,
        ST_CMD_REJ  = 3'd2,
        ST_ACK_OK   = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_RISE = 2'd1,
        PEND_FALL = 2'd2
    } pend_t;

    // One queued job: a single status result or a whole mode frame.
    typedef struct packed {
        logic             frame;
        status_t          status;
        logic             aim;
        logic             cmd_ok;
        logic             ack_wait;
        logic [MSG_W-1:0] msg;
    } job_t;

endpackage

`default_nettype wire

// File: rtl/vlmh_front.sv
// Front end: takes items, parses received frames, tracks mode state and queues jobs.
`default_nettype none

module vlmh_front
    import vlmh_pkg::*;
#(
    parameter int FRAME_BYTES   = 15,
    parameter int BURST_BYTES   = 36,
    parameter int CMD_MSG_BYTES = 6
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] cmd,
    input  wire logic [7:0] rx_byte,
    input  wire logic       burst_end,
    input  wire logic       key_pressed,
    output logic            push,
    output job_t            job,
    input  wire logic       q_full
);

    localparam int PAY_LEN   = FRAME_BYTES - 3;
    localparam int FC_W      = $clog2(FRAME_BYTES);
    localparam int BC_W      = $clog2(BURST_BYTES);
    localparam bit ACK_FITS  = (PAY_LEN >= 3);

    logic [7:0]       store_reg [FRAME_BYTES];
    logic [FC_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic [BC_W-1:0]  burst_cnt_reg, burst_cnt_next;
    logic             aim_reg, aim_next;
    pend_t            pend_reg, pend_next;
    logic             last_key_reg, last_key_next;
    logic             ack_wait_reg, ack_wait_next;
    logic             cmd_ok_reg, cmd_ok_next;
    logic [MSG_W-1:0] cmd_store_reg, cmd_store_next;

    logic                       accept;
    cmd_t                       cmd_e;
    logic [7:0]                 pay [PAY_LEN];
    logic                       frame_ok;
    logic                       cmd_pad_ok;
    logic                       ack_match;
    logic [8*MSG_MAX_BYTES-1:0] msg_full;
    status_t                    status;
    logic                       send_frame;

    assign cmd_e    = cmd_t'(cmd);
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // frame checks, in parallel over the payload
    always_comb
    begin
        for (int i = 0; i < PAY_LEN; i++)
        begin
            pay[i] = store_reg[i + 2];
        end
        frame_ok   = (store_reg[0] == SYM_STX) && (rx_byte == SYM_ETX);
        cmd_pad_ok = 1'b1;
        ack_match  = ACK_FITS;
        msg_full   = '0;
        for (int i = 0; i < PAY_LEN; i++)
        begin
            if (i >= CMD_MSG_BYTES)
            begin
                cmd_pad_ok = cmd_pad_ok && (pay[i] == SYM_PAD);
            end
            else if (i < MSG_MAX_BYTES)
            begin
                msg_full[8*i +: 8] = pay[i];
            end
            if (i < 3)
            begin
                ack_match = ack_match && (pay[i] == ACK_TEXT[i]);
            end
            else
            begin
                ack_match = ack_match && (pay[i] == SYM_PAD);
            end
        end
    end

    always_comb
    begin
        frame_cnt_next = frame_cnt_reg;
        burst_cnt_next = burst_cnt_reg;
        aim_next       = aim_reg;
        pend_next      = pend_reg;
        last_key_next  = last_key_reg;
        ack_wait_next  = ack_wait_reg;
        cmd_ok_next    = cmd_ok_reg;
        cmd_store_next = cmd_store_reg;
        status         = ST_NONE;
        send_frame     = 1'b0;
        unique case (cmd_e)
            CMD_BYTE:
            begin
                if (frame_cnt_reg == FC_W'(FRAME_BYTES - 1))
                begin
                    frame_cnt_next = '0;
                    if (!frame_ok)
                    begin
                        status = ST_IGNORED;
                    end
                    else if (store_reg[1] == TYPE_CMD)
                    begin
                        if (aim_reg && cmd_pad_ok)
                        begin
                            status         = ST_CMD_OK;
                            cmd_store_next = msg_full[MSG_W-1:0];
                            cmd_ok_next    = 1'b1;
                        end
                        else
                        begin
                            status      = ST_CMD_REJ;
                            cmd_ok_next = 1'b0;
                        end
                    end
                    else if (store_reg[1] == TYPE_ACK && ack_match)
                    begin
                        status        = ST_ACK_OK;
                        ack_wait_next = 1'b0;
                        pend_next     = PEND_NONE;
                    end
                    else
                    begin
                        status = ST_IGNORED;
                    end
                end
                else
                begin
                    frame_cnt_next = frame_cnt_reg + FC_W'(1);
                end
                if (burst_end || burst_cnt_reg == BC_W'(BURST_BYTES - 1))
                begin
                    frame_cnt_next = '0;
                    burst_cnt_next = '0;
                end
                else
                begin
                    burst_cnt_next = burst_cnt_reg + BC_W'(1);
                end
            end
            CMD_KEY:
            begin
                if (key_pressed != last_key_reg)
                begin
                    if (key_pressed)
                    begin
                        pend_next = aim_reg ? PEND_FALL : PEND_RISE;
                    end
                    last_key_next = key_pressed;
                end
            end
            CMD_POLL:
            begin
                if (pend_reg != PEND_NONE)
                begin
                    aim_next      = (pend_reg == PEND_RISE);
                    cmd_ok_next   = cmd_ok_reg && (pend_reg == PEND_RISE);
                    ack_wait_next = 1'b1;
                    send_frame    = 1'b1;
                end
            end
            CMD_NOP:
            begin
                status = ST_NONE;
            end
        endcase
    end

    always_comb
    begin
        push         = accept;
        job.frame    = send_frame;
        job.status   = status;
        job.aim      = aim_next;
        job.cmd_ok   = cmd_ok_next;
        job.ack_wait = ack_wait_next;
        job.msg      = cmd_store_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd_e == CMD_BYTE)
        begin
            store_reg[frame_cnt_reg] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_cnt_reg <= '0;
            burst_cnt_reg <= '0;
            aim_reg       <= 1'b0;
            pend_reg      <= PEND_NONE;
            last_key_reg  <= 1'b0;
            ack_wait_reg  <= 1'b0;
            cmd_ok_reg    <= 1'b0;
            cmd_store_reg <= '0;
        end
        else if (accept)
        begin
            frame_cnt_reg <= frame_cnt_next;
            burst_cnt_reg <= burst_cnt_next;
            aim_reg       <= aim_next;
            pend_reg      <= pend_next;
            last_key_reg  <= last_key_next;
            ack_wait_reg  <= ack_wait_next;
            cmd_ok_reg    <= cmd_ok_next;
            cmd_store_reg <= cmd_store_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd_e == CMD_POLL && pend_reg != PEND_NONE |=> ack_wait_reg)
        else $error("poll with armed toggle did not set ack wait");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && status == ST_ACK_OK |=> !ack_wait_reg && pend_reg == PEND_NONE)
        else $error("ack did not clear wait and pending edge");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd_e == CMD_BYTE && burst_end |=> frame_cnt_reg == '0 && burst_cnt_reg == '0)
        else $error("burst end did not restart framing");
`endif

endmodule

`default_nettype wire

// File: rtl/vlmh_queue.sv
// Short job queue between the front end and the result sequencer.
`default_nettype none

module vlmh_queue
    import vlmh_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t job_in,
    output logic      full,
    input  wire logic pop,
    output job_t      job_out,
    output logic      empty
);

    job_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    assign full    = (count_reg == Q_CW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + Q_CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - Q_CW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full) && !(pop && empty))
        else $error("queue overflow or underflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> !empty)
        else $error("queue empty after push");
`endif

endmodule

`default_nettype wire

// File: rtl/vlmh_back.sv
// Result sequencer: expands queued jobs into results through an output register.
`default_nettype none

module vlmh_back
    import vlmh_pkg::*;
#(
    parameter int FRAME_BYTES = 15
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire job_t              job,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   tx_valid,
    output logic [7:0]             tx_byte,
    output logic                   last,
    output logic [2:0]             frame_status,
    output logic [2:0]             mode_bits,
    output logic                   command_valid,
    output logic                   waiting_ack,
    output logic [MSG_W-1:0]       command_message
);

    localparam int FC_W = $clog2(FRAME_BYTES);

    logic             out_valid_reg, out_valid_next;
    logic [FC_W-1:0]  idx_reg, idx_next;
    logic             tx_valid_reg;
    logic [7:0]       tx_byte_reg, tx_byte_next;
    logic             last_reg, last_next;
    status_t          status_reg;
    logic             aim_reg;
    logic             cmd_ok_reg;
    logic             ack_wait_reg;
    logic [MSG_W-1:0] msg_reg;

    logic load;
    logic idx_last;

    assign load     = !out_valid_reg || !out_stall;
    assign idx_last = (idx_reg == FC_W'(FRAME_BYTES - 1));

    always_comb
    begin
        pop            = 1'b0;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        last_next      = 1'b1;
        tx_byte_next   = 8'h00;
        if (job.frame)
        begin
            last_next = idx_last;
            if (idx_reg == '0)
            begin
                tx_byte_next = SYM_STX;
            end
            else if (idx_reg == FC_W'(1))
            begin
                tx_byte_next = TYPE_MODE;
            end
            else if (idx_last)
            begin
                tx_byte_next = SYM_ETX;
            end
            else if (idx_reg == FC_W'(2))
            begin
                tx_byte_next = {7'd0, job.aim};
            end
            else
            begin
                tx_byte_next = SYM_PAD;
            end
        end
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                if (!job.frame || idx_last)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + FC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            tx_valid_reg <= job.frame;
            tx_byte_reg  <= tx_byte_next;
            last_reg     <= last_next;
            status_reg   <= job.status;
            aim_reg      <= job.aim;
            cmd_ok_reg   <= job.cmd_ok;
            ack_wait_reg <= job.ack_wait;
            msg_reg      <= job.msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tx_valid        = tx_valid_reg;
    assign tx_byte         = tx_byte_reg;
    assign last            = last_reg;
    assign frame_status    = status_reg;
    assign mode_bits       = {2'b00, aim_reg};
    assign command_valid   = cmd_ok_reg;
    assign waiting_ack     = ack_wait_reg;
    assign command_message = msg_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tx_valid_reg && last_reg |-> tx_byte_reg == SYM_ETX)
        else $error("mode frame does not end in ETX");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !tx_valid_reg |-> last_reg && tx_byte_reg == 8'h00)
        else $error("status result malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tx_valid_reg |-> status_reg == ST_NONE && ack_wait_reg)
        else $error("mode frame byte with status or without ack wait");
`endif

endmodule

`default_nettype wire

// File: rtl/vision_link_mode_handshake.sv
// Top level of the vision link mode handshake block.
// Takes one item per cycle while not stalled (received byte, key sample, poll tick or
// no-op). Each item gives one result, except a poll tick with a key toggle armed, which
// gives a FRAME_BYTES-byte mode frame, one byte per cycle from the output register while
// out_stall is low. Frame checks and state updates finish in the cycle an item is
// accepted; the job then waits in a two-entry queue until the sequencer loads its first
// result into the output register. The input stalls only while the queue is full, i.e.
// while a mode frame is being sent out or the output side is stalled. No clearing pass
// is needed after reset.
`default_nettype none

module vision_link_mode_handshake
    import vlmh_pkg::*;
#(
    parameter int FRAME_BYTES   = 15,
    parameter int BURST_BYTES   = 36,
    parameter int CMD_MSG_BYTES = 6
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        cmd,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              burst_end,
    input  wire logic              key_pressed,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   tx_valid,
    output logic [7:0]             tx_byte,
    output logic                   last,
    output logic [2:0]             frame_status,
    output logic [2:0]             mode_bits,
    output logic                   command_valid,
    output logic                   waiting_ack,
    output logic [MSG_W-1:0]       command_message
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    job_t job_in;
    job_t job_out;

    vlmh_front #(
        .FRAME_BYTES   (FRAME_BYTES),
        .BURST_BYTES   (BURST_BYTES),
        .CMD_MSG_BYTES (CMD_MSG_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .rx_byte     (rx_byte),
        .burst_end   (burst_end),
        .key_pressed (key_pressed),
        .push        (push),
        .job         (job_in),
        .q_full      (q_full)
    );

    vlmh_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .full    (q_full),
        .pop     (pop),
        .job_out (job_out),
        .empty   (q_empty)
    );

    vlmh_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job             (job_out),
        .empty           (q_empty),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tx_valid        (tx_valid),
        .tx_byte         (tx_byte),
        .last            (last),
        .frame_status    (frame_status),
        .mode_bits       (mode_bits),
        .command_valid   (command_valid),
        .waiting_ack     (waiting_ack),
        .command_message (command_message)
    );

endmodule

`default_nettype wire
